### src/b64u_pkg.sv
package b64u_pkg;

   localparam int unsigned BYTE_W  = 8;
   localparam int unsigned SEXT_W  = 6;
   localparam int unsigned PHASE_W = 2;

   localparam logic [BYTE_W-1:0] CHAR_UPPER_A = 8'h41;
   localparam logic [BYTE_W-1:0] CHAR_UPPER_Z = 8'h5a;
   localparam logic [BYTE_W-1:0] CHAR_LOWER_A = 8'h61;
   localparam logic [BYTE_W-1:0] CHAR_LOWER_Z = 8'h7a;
   localparam logic [BYTE_W-1:0] CHAR_DIGIT_0 = 8'h30;
   localparam logic [BYTE_W-1:0] CHAR_DIGIT_9 = 8'h39;
   localparam logic [BYTE_W-1:0] CHAR_PLUS    = 8'h2b;
   localparam logic [BYTE_W-1:0] CHAR_SLASH   = 8'h2f;

   localparam logic [SEXT_W-1:0] IDX_LOWER = 6'd26;
   localparam logic [SEXT_W-1:0] IDX_DIGIT = 6'd52;
   localparam logic [SEXT_W-1:0] IDX_PLUS  = 6'd62;
   localparam logic [SEXT_W-1:0] IDX_SLASH = 6'd63;

   localparam logic [PHASE_W-1:0] PHASE_0 = 2'd0;
   localparam logic [PHASE_W-1:0] PHASE_1 = 2'd1;
   localparam logic [PHASE_W-1:0] PHASE_2 = 2'd2;
   localparam logic [PHASE_W-1:0] PHASE_3 = 2'd3;

   localparam logic DIR_ENCODE = 1'b0;
   localparam logic DIR_DECODE = 1'b1;

   typedef struct packed {
      logic [BYTE_W-1:0] data;
      logic              last;
      logic              error;
   } result_type;

   typedef struct packed {
      logic [1:0] count;
      result_type slot0;
      result_type slot1;
   } pair_type;

   typedef struct packed {
      logic              valid;
      logic [SEXT_W-1:0] value;
   } sextet_type;

   // 6-bit index to alphabet character
   function automatic logic [BYTE_W-1:0] to_char(input logic [SEXT_W-1:0] v);
      logic [BYTE_W-1:0] c;
      if (v < IDX_LOWER) begin
         c = CHAR_UPPER_A + {2'b00, v};
      end else if (v < IDX_DIGIT) begin
         c = CHAR_LOWER_A + {2'b00, v - IDX_LOWER};
      end else if (v < IDX_PLUS) begin
         c = CHAR_DIGIT_0 + {2'b00, v - IDX_DIGIT};
      end else if (v == IDX_PLUS) begin
         c = CHAR_PLUS;
      end else begin
         c = CHAR_SLASH;
      end
      return c;
   endfunction

   function automatic sextet_type from_char(input logic [BYTE_W-1:0] c);
      sextet_type s;
      s.valid = 1'b1;
      s.value = '0;
      if (c >= CHAR_UPPER_A && c <= CHAR_UPPER_Z) begin
         s.value = SEXT_W'(c - CHAR_UPPER_A);
      end else if (c >= CHAR_LOWER_A && c <= CHAR_LOWER_Z) begin
         s.value = SEXT_W'(c - CHAR_LOWER_A) + IDX_LOWER;
      end else if (c >= CHAR_DIGIT_0 && c <= CHAR_DIGIT_9) begin
         s.value = SEXT_W'(c - CHAR_DIGIT_0) + IDX_DIGIT;
      end else if (c == CHAR_PLUS) begin
         s.value = IDX_PLUS;
      end else if (c == CHAR_SLASH) begin
         s.value = IDX_SLASH;
      end else begin
         s.valid = 1'b0;
      end
      return s;
   endfunction

endpackage

### src/base64_codec_unpadded.sv
// A request passes the input register and then the result register before its results appear.
// Throughput: one request per cycle when it yields at most one result and rsp_tready is high;
// a request yielding two characters (encode) holds the result register until both are taken,
// one result per cycle. A request that yields no result still passes the result register.
// Reset (synchronous, active high): encode direction, group state and error drop cleared.
module base64_codec_unpadded (
   input  logic       clock,
   input  logic       reset,
   input  logic       csr_wr_en,
   input  logic       csr_wr_data,   // direction
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,     // [7:0] in_byte
   input  logic       req_tlast,     // in_last
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata,     // [7:0] out_byte
   output logic       rsp_tlast,     // out_last
   output logic       rsp_tuser      // [0] out_error
);
   import b64u_pkg::*;

   logic              in_valid_ff, in_valid_in;
   logic [BYTE_W-1:0] in_byte_ff;
   logic              in_last_ff;
   logic              req_fire;
   logic              advance;
   logic              can_load;
   pair_type          pair;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         in_byte_ff <= req_tdata;
         in_last_ff <= req_tlast;
      end
   end

   always_comb begin
      advance     = in_valid_ff && can_load;
      req_tready  = !in_valid_ff || advance;
      req_fire    = req_tvalid && req_tready;
      in_valid_in = req_fire || (in_valid_ff && !advance);
   end

   b64u_core u_core (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .item_go     (advance),
      .item_byte   (in_byte_ff),
      .item_last   (in_last_ff),
      .pair        (pair)
   );

   b64u_out_buf u_out_buf (
      .clock      (clock),
      .reset      (reset),
      .load       (advance),
      .pair       (pair),
      .can_load   (can_load),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)
   );

endmodule

### src/b64u_core.sv
module b64u_core (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      csr_wr_en,
   input  logic                      csr_wr_data,
   input  logic                      item_go,
   input  logic [b64u_pkg::BYTE_W-1:0] item_byte,
   input  logic                      item_last,
   output b64u_pkg::pair_type        pair
);
   import b64u_pkg::*;

   logic               direction_ff, direction_in;
   logic [PHASE_W-1:0] phase_ff, phase_in;
   logic [SEXT_W-1:0]  carry_ff, carry_in;
   logic               discard_ff, discard_in;

   sextet_type sx;

   always_ff @(posedge clock) begin
      if (reset) begin
         direction_ff <= DIR_ENCODE;
         phase_ff     <= PHASE_0;
         carry_ff     <= '0;
         discard_ff   <= 1'b0;
      end else begin
         direction_ff <= direction_in;
         phase_ff     <= phase_in;
         carry_ff     <= carry_in;
         discard_ff   <= discard_in;
      end
   end

   always_comb begin
      sx           = from_char(item_byte);
      direction_in = direction_ff;
      phase_in     = phase_ff;
      carry_in     = carry_ff;
      discard_in   = discard_ff;
      pair         = '0;

      if (discard_ff) begin
         if (item_last) begin
            discard_in = 1'b0;
            phase_in   = PHASE_0;
            carry_in   = '0;
         end
      end else if (direction_ff == DIR_DECODE) begin
         if (!sx.valid || (item_last && phase_ff == PHASE_0)) begin
            pair.count       = 2'd1;
            pair.slot0.last  = 1'b1;
            pair.slot0.error = 1'b1;
            phase_in         = PHASE_0;
            carry_in         = '0;
            discard_in       = !item_last;
         end else begin
            pair.slot0.last = item_last;
            case (phase_ff)
               PHASE_0: begin
                  carry_in = sx.value;
                  phase_in = PHASE_1;
               end
               PHASE_1: begin
                  pair.count      = 2'd1;
                  pair.slot0.data = {carry_ff, sx.value[5:4]};
                  carry_in        = {2'b00, sx.value[3:0]};
                  phase_in        = PHASE_2;
               end
               PHASE_2: begin
                  pair.count      = 2'd1;
                  pair.slot0.data = {carry_ff[3:0], sx.value[5:2]};
                  carry_in        = {4'b0000, sx.value[1:0]};
                  phase_in        = PHASE_3;
               end
               default: begin
                  pair.count      = 2'd1;
                  pair.slot0.data = {carry_ff[1:0], sx.value};
                  carry_in        = '0;
                  phase_in        = PHASE_0;
               end
            endcase
            if (item_last) begin
               phase_in = PHASE_0;
               carry_in = '0;
            end
         end
      end else begin
         case (phase_ff)
            PHASE_1: begin
               pair.count      = 2'd1;
               pair.slot0.data = to_char({carry_ff[1:0], item_byte[7:4]});
               pair.slot1.data = to_char({item_byte[3:0], 2'b00});
               carry_in        = {2'b00, item_byte[3:0]};
               phase_in        = PHASE_2;
            end
            PHASE_2: begin
               pair.count      = 2'd2;
               pair.slot0.data = to_char({carry_ff[3:0], item_byte[7:6]});
               pair.slot1.data = to_char(item_byte[5:0]);
               carry_in        = '0;
               phase_in        = PHASE_0;
            end
            default: begin
               // phase 3 never occurs in encode; handled as phase 0
               pair.count      = 2'd1;
               pair.slot0.data = to_char(item_byte[7:2]);
               pair.slot1.data = to_char({item_byte[1:0], 4'b0000});
               carry_in        = {4'b0000, item_byte[1:0]};
               phase_in        = PHASE_1;
            end
         endcase
         // every encode tail ends on a second character carrying last
         if (item_last) begin
            pair.count      = 2'd2;
            pair.slot1.last = 1'b1;
            phase_in        = PHASE_0;
            carry_in        = '0;
         end
      end

      if (!item_go) begin
         direction_in = direction_ff;
         phase_in     = phase_ff;
         carry_in     = carry_ff;
         discard_in   = discard_ff;
      end
      if (csr_wr_en) begin
         direction_in = csr_wr_data;
         phase_in     = PHASE_0;
         carry_in     = '0;
         discard_in   = 1'b0;
      end
   end

endmodule

### src/b64u_out_buf.sv
module b64u_out_buf (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        load,
   input  b64u_pkg::pair_type          pair,
   output logic                        can_load,
   output logic                        rsp_tvalid,
   input  logic                        rsp_tready,
   output logic [b64u_pkg::BYTE_W-1:0] rsp_tdata,
   output logic                        rsp_tlast,
   output logic                        rsp_tuser
);
   import b64u_pkg::*;

   logic [1:0] count_ff, count_in;
   result_type slot0_ff, slot0_in;
   result_type slot1_ff, slot1_in;
   logic       rsp_fire;

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= 2'd0;
      end else begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      slot0_ff <= slot0_in;
      slot1_ff <= slot1_in;
   end

   always_comb begin
      rsp_fire = rsp_tvalid && rsp_tready;
      can_load = (count_ff == 2'd0) || (count_ff == 2'd1 && rsp_fire);
      count_in = count_ff;
      slot0_in = slot0_ff;
      slot1_in = slot1_ff;
      if (load) begin
         count_in = pair.count;
         slot0_in = pair.slot0;
         slot1_in = pair.slot1;
      end else if (rsp_fire) begin
         count_in = count_ff - 2'd1;
         slot0_in = slot1_ff;
      end
   end

   assign rsp_tvalid = (count_ff != 2'd0);
   assign rsp_tdata  = slot0_ff.data;
   assign rsp_tlast  = slot0_ff.last;
   assign rsp_tuser  = slot0_ff.error;

endmodule

### src/b64u_checker.sv
module b64u_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_tready,
   input logic       rsp_tvalid,
   input logic       rsp_tready,
   input logic [7:0] rsp_tdata,
   input logic       rsp_tlast,
   input logic       rsp_tuser
);

   // an error result always closes the message
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> rsp_tlast)
      else $error("error result without last");

   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> rsp_tdata == 8'h00)
      else $error("error result with nonzero data");

   assert property (@(posedge clock)
      reset |=> !rsp_tvalid && req_tready)
      else $error("not empty after reset");

   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata)
         && $stable(rsp_tlast) && $stable(rsp_tuser))
      else $error("stalled result changed");

endmodule

bind base64_codec_unpadded b64u_checker u_checker (.*);

### sim/tb_base64_codec_unpadded.sv
`timescale 1ns / 100ps

module tb_base64_codec_unpadded;
   import b64u_pkg::*;

   localparam int STALL_LIMIT  = 4000;
   localparam int DRAIN_CYCLES = 8;
   localparam int BURST_ITEMS  = 210;

   typedef struct {
      logic [BYTE_W-1:0] data;
      logic              last;
   } req_item_type;

   logic       clock;
   logic       reset       = 1'b1;
   logic       csr_wr_en   = 1'b0;
   logic       csr_wr_data = DIR_ENCODE;
   logic       req_tvalid  = 1'b0;
   logic       req_tready;
   logic [7:0] req_tdata   = '0;   // [7:0] in_byte
   logic       req_tlast   = 1'b0; // in_last
   logic       rsp_tvalid;
   logic       rsp_tready  = 1'b0;
   logic [7:0] rsp_tdata;          // [7:0] out_byte
   logic       rsp_tlast;          // out_last
   logic       rsp_tuser;          // [0] out_error

   // codec model state
   logic [BYTE_W-1:0]  alpha [64];
   int                 sext_of [256];
   logic               dir_mode  = DIR_ENCODE;
   logic [PHASE_W-1:0] grp_phase = PHASE_0;
   logic [SEXT_W-1:0]  grp_carry = '0;
   logic               dropping  = 1'b0;

   req_item_type tx_bytes [$];
   result_type   expected_out [$];

   int           send_idle_pct = 6;
   int           recv_idle_pct = 54;
   bit           req_fire      = 1'b0;
   int           stall_cycles  = 0;
   int           mismatches    = 0;
   req_item_type next_req;
   result_type   want;
   result_type   got;

   base64_codec_unpadded dut (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tlast   (req_tlast),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tlast   (rsp_tlast),
      .rsp_tuser   (rsp_tuser)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   function automatic void build_tables();
      for (int i = 0; i < 256; i++) sext_of[8'(i)] = -1;
      for (int i = 0; i < 26; i++) begin
         alpha[6'(i)]      = CHAR_UPPER_A + 8'(i);
         alpha[6'(26 + i)] = CHAR_LOWER_A + 8'(i);
      end
      for (int i = 0; i < 10; i++) alpha[6'(52 + i)] = CHAR_DIGIT_0 + 8'(i);
      alpha[62] = CHAR_PLUS;
      alpha[63] = CHAR_SLASH;
      // decode lookup is the inverse of the encode table
      for (int i = 0; i < 64; i++) sext_of[alpha[6'(i)]] = i;
   endfunction

   function automatic void clear_group();
      grp_phase = PHASE_0;
      grp_carry = '0;
   endfunction

   function automatic void encode_step(input logic [7:0] b, input logic last);
      result_type chars [3];
      logic [1:0] n;
      n = 2'd0;
      for (int i = 0; i < 3; i++) begin
         chars[2'(i)].data  = '0;
         chars[2'(i)].last  = 1'b0;
         chars[2'(i)].error = 1'b0;
      end
      case (grp_phase)
         PHASE_1: begin
            chars[n].data = alpha[{grp_carry[1:0], b[7:4]}];
            n = n + 2'd1;
            grp_carry = {2'b00, b[3:0]};
            grp_phase = PHASE_2;
         end
         PHASE_2: begin
            chars[n].data = alpha[{grp_carry[3:0], b[7:6]}];
            n = n + 2'd1;
            chars[n].data = alpha[b[5:0]];
            n = n + 2'd1;
            grp_carry = '0;
            grp_phase = PHASE_0;
         end
         default: begin
            chars[n].data = alpha[b[7:2]];
            n = n + 2'd1;
            grp_carry = {4'b0000, b[1:0]};
            grp_phase = PHASE_1;
         end
      endcase
      if (last) begin
         // flush the partial group, zero filled, no padding
         if (grp_phase == PHASE_1) begin
            chars[n].data = alpha[{grp_carry[1:0], 4'b0000}];
            n = n + 2'd1;
         end else if (grp_phase == PHASE_2) begin
            chars[n].data = alpha[{grp_carry[3:0], 2'b00}];
            n = n + 2'd1;
         end
         chars[n - 2'd1].last = 1'b1;
         clear_group();
      end
      for (int i = 0; i < int'(n); i++) expected_out.push_back(chars[2'(i)]);
   endfunction

   function automatic void decode_step(input logic [7:0] c, input logic last);
      result_type        r;
      logic [SEXT_W-1:0] v;
      r.data  = '0;
      r.last  = last;
      r.error = 1'b0;
      if (sext_of[c] < 0 || (last && grp_phase == PHASE_0)) begin
         // bad character or lone tail character
         r.last  = 1'b1;
         r.error = 1'b1;
         expected_out.push_back(r);
         clear_group();
         dropping = !last;
      end else begin
         v = SEXT_W'(sext_of[c]);
         case (grp_phase)
            PHASE_0: begin
               grp_carry = v;
               grp_phase = PHASE_1;
            end
            PHASE_1: begin
               r.data = {grp_carry, v[5:4]};
               expected_out.push_back(r);
               grp_carry = {2'b00, v[3:0]};
               grp_phase = PHASE_2;
            end
            PHASE_2: begin
               r.data = {grp_carry[3:0], v[5:2]};
               expected_out.push_back(r);
               grp_carry = {4'b0000, v[1:0]};
               grp_phase = PHASE_3;
            end
            default: begin
               r.data = {grp_carry[1:0], v};
               expected_out.push_back(r);
               grp_carry = '0;
               grp_phase = PHASE_0;
            end
         endcase
         if (last) clear_group();
      end
   endfunction

   function automatic void codec_step(input logic [7:0] b, input logic last);
      if (dropping) begin
         if (last) begin
            dropping = 1'b0;
            clear_group();
         end
      end else if (dir_mode == DIR_DECODE) begin
         decode_step(b, last);
      end else begin
         encode_step(b, last);
      end
   endfunction

   task automatic note_mismatch(input bit unexpected, input result_type exp_r,
                                input result_type got_r);
      mismatches++;
      if (mismatches <= 10) begin
         if (unexpected) begin
            $display("ERROR: unexpected response data=%02h last=%b error=%b",
                     got_r.data, got_r.last, got_r.error);
         end else begin
            $display("ERROR: response expected data=%02h last=%b error=%b, got %02h %b %b",
                     exp_r.data, exp_r.last, exp_r.error, got_r.data, got_r.last, got_r.error);
         end
      end
   endtask

   // request driver and response ready driver
   always @(negedge clock) begin
      if (!req_tvalid || req_fire) begin
         if (tx_bytes.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
            next_req = tx_bytes.pop_front();
            req_tvalid <= 1'b1;
            req_tdata  <= next_req.data;
            req_tlast  <= next_req.last;
         end else begin
            req_tvalid <= 1'b0;
         end
      end
      rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
   end

   // monitor, checker and watchdog
   always @(posedge clock) begin
      req_fire = !reset && req_tvalid && req_tready;
      if (req_fire) codec_step(req_tdata, req_tlast);
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.data  = rsp_tdata;
         got.last  = rsp_tlast;
         got.error = rsp_tuser;
         if (expected_out.size() == 0) begin
            note_mismatch(1'b1, got, got);
         end else begin
            want = expected_out.pop_front();
            if (got.data !== want.data || got.last !== want.last || got.error !== want.error)
               note_mismatch(1'b0, want, got);
         end
      end
      if (reset || req_fire || (rsp_tvalid && rsp_tready)) stall_cycles = 0;
      else stall_cycles++;
      if (stall_cycles >= STALL_LIMIT) begin
         $display("base64_codec_unpadded test failed");
         $finish;
      end
   end

   function automatic void push_item(input logic [7:0] b, input logic last);
      req_item_type it;
      it.data = b;
      it.last = last;
      tx_bytes.push_back(it);
   endfunction

   function automatic void push_text(input string s, input bit closed = 1'b1);
      for (int i = 0; i < s.len(); i++) push_item(s[i], closed && i == s.len() - 1);
   endfunction

   function automatic int queue_encode_msg();
      int len;
      len = ($urandom_range(9) == 0) ? $urandom_range(40, 16) : $urandom_range(7, 1);
      for (int i = 0; i < len; i++) push_item(8'($urandom_range(255)), i == len - 1);
      return len;
   endfunction

   function automatic int queue_decode_msg();
      int         kind;
      int         len;
      int         bad_at;
      logic [7:0] c;
      kind = $urandom_range(99);
      len  = $urandom_range(16, 2);
      if (kind < 72) begin
         if (len % 4 == 1) len++;
      end else if (kind < 82) begin
         len = 4 * $urandom_range(3, 0) + 1;
      end else if (kind >= 94) begin
         len = $urandom_range(8, 1);
      end
      bad_at = (kind >= 82 && kind < 94) ? $urandom_range(len - 1) : -1;
      for (int i = 0; i < len; i++) begin
         if (kind >= 94) begin
            c = 8'($urandom_range(255));
         end else if (i == bad_at) begin
            do c = 8'($urandom_range(255)); while (sext_of[c] >= 0);
         end else begin
            c = alpha[6'($urandom_range(63))];
         end
         push_item(c, i == len - 1);
      end
      return len;
   endfunction

   // sender holds off until every response is back and the pipe is empty
   task automatic settle();
      do @(negedge clock); while (tx_bytes.size() != 0 || req_tvalid || expected_out.size() != 0);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   task automatic set_direction(input logic d);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= d;
      dir_mode = d;
      dropping = 1'b0;
      clear_group();
      @(negedge clock);
      csr_wr_en <= 1'b0;
   endtask

   initial begin
      int budget;
      build_tables();
      repeat (8) @(negedge clock);
      reset <= 1'b0;

      // encode: byte extremes, 1- and 2-byte tails, open message cut by a write
      push_item(8'h00, 1'b1);
      push_item(8'hff, 1'b1);
      push_text("Ma");
      push_text("M", 1'b0);
      settle();
      set_direction(DIR_DECODE);

      // decode: full group, symbols, lone tail, bad first char, bad last char, open message cut by a write
      push_text("TWFu");
      push_text("/+9a");
      push_text("A");
      push_text("*BC");
      push_text("AB=");
      push_text("QU", 1'b0);
      settle();
      set_direction(DIR_DECODE);
      push_text("QUJ");

      for (int stage = 0; stage < 3; stage++) begin
         for (int d = 0; d < 2; d++) begin
            settle();
            if (d == 0) begin
               send_idle_pct = (stage == 0) ? 6 : (stage == 1) ? 54 : 0;
               recv_idle_pct = (stage == 0) ? 54 : (stage == 1) ? 6 : 0;
            end
            set_direction(d ? DIR_DECODE : DIR_ENCODE);
            budget = 0;
            while (budget < BURST_ITEMS)
               budget += d ? queue_decode_msg() : queue_encode_msg();
         end
      end
      settle();

      if (mismatches == 0) begin
         $display("base64_codec_unpadded test passed");
      end else begin
         $display("base64_codec_unpadded test failed");
      end
      $finish;
   end

endmodule
